// File: rtl/core/b58_pkg.sv
package b58_pkg;

  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CARRY_W = 6;
  localparam int unsigned RADIX = 58;
  localparam logic [7:0] ZERO_CHAR = 8'h31;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] val;
  } digit_t;

  // alphabet lookup: digits 1 to 9, upper case without I and O, lower case without l
  function automatic digit_t b58_digit(input logic [7:0] ch);
    digit_t d;
    logic [7:0] t;
    d.ok = 1'b1;
    t = 8'd0;
    if (ch >= 8'h31 && ch <= 8'h39) begin
      t = ch - 8'h31;
    end else if (ch >= 8'h41 && ch <= 8'h48) begin
      t = ch - 8'h41 + 8'd9;
    end else if (ch >= 8'h4a && ch <= 8'h4e) begin
      t = ch - 8'h4a + 8'd17;
    end else if (ch >= 8'h50 && ch <= 8'h5a) begin
      t = ch - 8'h50 + 8'd22;
    end else if (ch >= 8'h61 && ch <= 8'h6b) begin
      t = ch - 8'h61 + 8'd33;
    end else if (ch >= 8'h6d && ch <= 8'h7a) begin
      t = ch - 8'h6d + 8'd44;
    end else begin
      d.ok = 1'b0;
    end
    d.val = t[DIGIT_W-1:0];
    return d;
  endfunction

endpackage

// File: rtl/core/b58_mac.sv
module b58_mac
  import b58_pkg::*;
(
  input  logic [7:0]         byte_in,
  input  logic [CARRY_W-1:0] carry_in,
  output logic [7:0]         byte_out,
  output logic [CARRY_W-1:0] carry_out
);

  logic [13:0] prod;
  logic [13:0] sum;

  // byte * 58 as 64x - 4x - 2x
  assign prod = {byte_in, 6'd0} - {4'd0, byte_in, 2'd0} - {5'd0, byte_in, 1'd0};
  assign sum  = prod + {{(14-CARRY_W){1'b0}}, carry_in};
  assign byte_out  = sum[7:0];
  assign carry_out = sum[8 +: CARRY_W];

endmodule

// File: rtl/core/b58_store.sv
module b58_store #(
  parameter int unsigned DEPTH = 48,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/base58_decoder.sv
// channel  | ports                                  | handshake
// ---------+----------------------------------------+-----------------------------
// item in  | symbol, final_symbol                   | start high while busy low
// result   | data_byte, end_of_run, decode_error    | result_strobe, one cycle
//
// a character that folds into the store keeps busy high after acceptance:
// the shared multiply-accumulate walks the store one byte per cycle
// a final character then emits the leading zero bytes and then scans the store,
// which also clears the store; an all-'1' string needs no scan
// an error string answers on its final character without a scan, then clears the store
// synchronous reset starts the same clear; results cannot be held off
module base58_decoder
  import b58_pkg::*;
#(
  parameter int unsigned MAX_CHARS   = 64,
  parameter int unsigned STORE_BYTES = 48
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] symbol,
  input  logic       final_symbol,
  output logic       result_strobe,
  output logic [7:0] data_byte,
  output logic       end_of_run,
  output logic       decode_error
);

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [AW-1:0] LAST = AW'(STORE_BYTES - 1);
  localparam logic [6:0] MAX_CNT = 7'(MAX_CHARS);
  localparam logic [6:0] CAP_LAST = 7'd63;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_ZEROS,
    S_SCAN,
    S_ERR_CLR
  } state_t;

  state_t state;

  // per-string bookkeeping
  logic [6:0] zero_prefix_count;
  logic       in_prefix;
  logic [6:0] symbols_seen;
  logic       error_seen;
  logic       pending_final;

  // walk control
  logic [AW-1:0]      rd_ptr;
  logic [AW-1:0]      wr_ptr;
  logic               primed;
  logic [CARRY_W-1:0] carry;
  logic [6:0]         zero_cnt;
  logic [6:0]         emit_cnt;
  logic               started;

  // store port
  logic       st_we;
  logic [7:0] st_wdata;
  logic [7:0] st_rdata;

  // shared unit
  logic [7:0]         mac_byte;
  logic [CARRY_W-1:0] mac_carry;

  digit_t dig;
  logic   accept;
  logic   emit_byte;
  logic   capped;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign dig    = b58_digit(symbol);
  assign capped = emit_cnt[6];

  // the scan writes zero behind the read pointer, so the store is clean after a string
  always_comb begin
    st_we    = 1'b0;
    st_wdata = 8'd0;
    unique case (state)
      S_MAC: begin
        st_we    = primed;
        st_wdata = mac_byte;
      end
      S_SCAN:    st_we = primed;
      S_ERR_CLR: st_we = 1'b1;
      S_IDLE, S_ZEROS: st_we = 1'b0;
      default:   st_we = 1'b0;
    endcase
  end

  assign emit_byte = started || (st_rdata != 8'd0);

  b58_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .wr_addr (wr_ptr),
    .wr_data (st_wdata),
    .rd_addr (rd_ptr),
    .rd_data (st_rdata)
  );

  b58_mac u_mac (
    .byte_in   (st_rdata),
    .carry_in  (carry),
    .byte_out  (mac_byte),
    .carry_out (mac_carry)
  );

  always_ff @(posedge clk) begin
    result_strobe <= 1'b0;
    if (rst) begin
      // clear the store before the first item
      state             <= S_ERR_CLR;
      zero_prefix_count <= 7'd0;
      in_prefix         <= 1'b1;
      symbols_seen      <= 7'd0;
      error_seen        <= 1'b0;
      pending_final     <= 1'b0;
      primed            <= 1'b0;
      started           <= 1'b0;
      zero_cnt          <= 7'd0;
      emit_cnt          <= 7'd0;
      rd_ptr            <= '0;
      wr_ptr            <= '0;
      carry             <= '0;
      data_byte         <= 8'd0;
      end_of_run        <= 1'b0;
      decode_error      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            automatic logic err_now = error_seen;
            automatic logic do_mac  = 1'b0;
            pending_final <= final_symbol;
            if (!error_seen) begin
              if (symbols_seen >= MAX_CNT) begin
                err_now = 1'b1;
              end else begin
                symbols_seen <= symbols_seen + 7'd1;
                if (!dig.ok) begin
                  err_now = 1'b1;
                end else begin
                  do_mac = 1'b1;
                  if (in_prefix && symbol == ZERO_CHAR) begin
                    zero_prefix_count <= zero_prefix_count + 7'd1;
                  end else begin
                    in_prefix <= 1'b0;
                  end
                end
              end
            end
            error_seen <= err_now;
            if (do_mac) begin
              // fold the digit in from the least significant byte up
              carry  <= CARRY_W'(dig.val);
              rd_ptr <= LAST;
              primed <= 1'b0;
              state  <= S_MAC;
            end else if (final_symbol) begin
              // only errors reach here on a final character
              result_strobe <= 1'b1;
              data_byte     <= 8'd0;
              end_of_run    <= 1'b1;
              decode_error  <= 1'b1;
              wr_ptr        <= '0;
              state         <= S_ERR_CLR;
            end
          end
        end

        S_MAC: begin
          if (!primed) begin
            primed <= 1'b1;
            wr_ptr <= rd_ptr;
            rd_ptr <= rd_ptr - AW'(1);
          end else begin
            carry  <= mac_carry;
            wr_ptr <= rd_ptr;
            rd_ptr <= rd_ptr - AW'(1);
            if (wr_ptr == '0) begin
              // a carry out of the top byte means the store overflowed
              automatic logic err_now = (mac_carry != '0);
              error_seen <= err_now;
              primed     <= 1'b0;
              if (!pending_final) begin
                state <= S_IDLE;
              end else if (err_now) begin
                result_strobe <= 1'b1;
                data_byte     <= 8'd0;
                end_of_run    <= 1'b1;
                decode_error  <= 1'b1;
                wr_ptr        <= '0;
                state         <= S_ERR_CLR;
              end else if (zero_prefix_count != 7'd0) begin
                zero_cnt <= 7'd0;
                emit_cnt <= 7'd0;
                state    <= S_ZEROS;
              end else begin
                emit_cnt <= 7'd0;
                started  <= 1'b0;
                rd_ptr   <= '0;
                state    <= S_SCAN;
              end
            end
          end
        end

        S_ZEROS: begin
          // an all-'1' string leaves the store at zero, so the zeros are the whole answer
          result_strobe <= 1'b1;
          data_byte     <= 8'd0;
          decode_error  <= 1'b0;
          end_of_run    <= (in_prefix && zero_cnt == zero_prefix_count - 7'd1) ||
                           (emit_cnt == CAP_LAST);
          emit_cnt      <= emit_cnt + 7'd1;
          zero_cnt      <= zero_cnt + 7'd1;
          if (zero_cnt == zero_prefix_count - 7'd1) begin
            if (in_prefix) begin
              zero_prefix_count <= 7'd0;
              in_prefix         <= 1'b1;
              symbols_seen      <= 7'd0;
              error_seen        <= 1'b0;
              state             <= S_IDLE;
            end else begin
              started <= 1'b0;
              primed  <= 1'b0;
              rd_ptr  <= '0;
              state   <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (!primed) begin
            primed <= 1'b1;
            wr_ptr <= rd_ptr;
            rd_ptr <= rd_ptr + AW'(1);
          end else begin
            wr_ptr <= rd_ptr;
            rd_ptr <= rd_ptr + AW'(1);
            if (st_rdata != 8'd0) begin
              started <= 1'b1;
            end
            // skip leading zero bytes, stop output once the result limit is hit
            if (emit_byte && !capped) begin
              result_strobe <= 1'b1;
              data_byte     <= st_rdata;
              decode_error  <= 1'b0;
              end_of_run    <= (wr_ptr == LAST) || (emit_cnt == CAP_LAST);
              emit_cnt      <= emit_cnt + 7'd1;
            end
            if (wr_ptr == LAST) begin
              primed            <= 1'b0;
              zero_prefix_count <= 7'd0;
              in_prefix         <= 1'b1;
              symbols_seen      <= 7'd0;
              error_seen        <= 1'b0;
              state             <= S_IDLE;
            end
          end
        end

        S_ERR_CLR: begin
          // after reset or an error item: wipe the store
          wr_ptr <= wr_ptr + AW'(1);
          if (wr_ptr == LAST) begin
            zero_prefix_count <= 7'd0;
            in_prefix         <= 1'b1;
            symbols_seen      <= 7'd0;
            error_seen        <= 1'b0;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
